[rtl/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types and constants for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic        part_last;
    } md5_out_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amount by round phase and round index low bits
    function automatic logic [4:0] rot_amount(input logic [1:0] phase, input logic [1:0] idx);
        logic [4:0] r;
        unique case (phase)
            2'd0: r = (idx == 2'd0) ? 5'd7 : (idx == 2'd1) ? 5'd12 :
                      (idx == 2'd2) ? 5'd17 : 5'd22;
            2'd1: r = (idx == 2'd0) ? 5'd5 : (idx == 2'd1) ? 5'd9 :
                      (idx == 2'd2) ? 5'd14 : 5'd20;
            2'd2: r = (idx == 2'd0) ? 5'd4 : (idx == 2'd1) ? 5'd11 :
                      (idx == 2'd2) ? 5'd16 : 5'd23;
            default: r = (idx == 2'd0) ? 5'd6 : (idx == 2'd1) ? 5'd10 :
                      (idx == 2'd2) ? 5'd15 : 5'd21;
        endcase
        return r;
    endfunction

    // message word index for round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] m;
        logic [3:0] rl;
        rl = r[3:0];
        unique case (r[5:4])
            2'd0: m = rl;
            2'd1: m = 4'(5 * rl + 1);
            2'd2: m = 4'(3 * rl + 5);
            default: m = 4'(7 * rl);
        endcase
        return m;
    endfunction

endpackage

[rtl/md5_message_digest_top.sv]
// A plain byte beat is accepted, then merged by a write into its block word; the 64th
//   byte of a block adds a compression (read setup, 64 rounds, fold).
// A close pads (one word write per cycle), writes the length and compresses once
//   or twice before the two digest beats.
// Items are taken one at a time, set by the single block-word port and round unit.
// Reset (aresetn, synchronous, low) restores chaining words, clears the bit count.
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 over a byte stream, block words held in a 16x32 synchronous memory.
// ----------------------------------------------------------------------------
module md5_message_digest_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,      // accept items
        ST_RMW,       // byte merge: read data now valid
        ST_PAD,       // write pad/zero bytes
        ST_RMWPAD,    // merge 0x80 into partial word
        ST_LEN_LO,
        ST_LEN_HI,
        ST_RD,        // issue first round read
        ST_ROUND,     // one round per cycle
        ST_FOLD,      // add into chaining words
        ST_OUT0,
        ST_OUT1
    } state_t;

    state_t      state_reg;
    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        rd_en;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;

    logic [31:0] ch_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bit_count_reg;
    logic [5:0]  round_reg;
    logic [7:0]  byte_reg;
    logic        closing_reg;   // message closing after current work
    logic        padded_reg;    // pad phase done for this close
    logic        second_reg;    // length goes into a fresh block
    logic [5:0]  pos_reg;       // byte merge and pad write position
    md5_pkg::md5_out_t out_reg;
    logic        out_valid_reg;

    // block memory, one write and one registered read per cycle;
    // a write without a read forwards the written word for a following merge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end else if (wr_en) begin
            rd_data_reg <= wr_data;
        end
    end

    logic [5:0]  cur_pos;
    logic [31:0] f_val, sum_val, rot_val;
    logic [4:0]  sh;
    logic [5:0]  next_round;
    assign cur_pos = bit_count_reg[8:3];
    assign next_round = round_reg + 6'd1;

    always_comb begin
        unique case (round_reg[5:4])
            2'd0: f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + md5_pkg::ROUND_ADD[round_reg] + rd_data_reg;
        sh = md5_pkg::rot_amount(round_reg[5:4], round_reg[1:0]);
        rot_val = (sum_val << sh) | (sum_val >> (6'd32 - {1'b0, sh}));
    end

    // memory port control
    always_comb begin
        rd_en = 1'b0;
        rd_addr = 4'd0;
        wr_en = 1'b0;
        wr_addr = 4'd0;
        wr_data = 32'd0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en = 1'b1;
                rd_addr = cur_pos[5:2];
            end
            ST_RMW: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[5:2];
                wr_data = (pos_reg[1:0] == 2'd0) ? {24'd0, byte_reg} :
                          (rd_data_reg | ({24'd0, byte_reg} << {pos_reg[1:0], 3'b000}));
            end
            ST_RMWPAD: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[5:2];
                wr_data = (pos_reg[1:0] == 2'd0) ? {24'd0, md5_pkg::PAD_BYTE} :
                          ((rd_data_reg & ~(32'hffffffff << {pos_reg[1:0], 3'b000}))
                           | ({24'd0, md5_pkg::PAD_BYTE} << {pos_reg[1:0], 3'b000}));
            end
            ST_PAD: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[5:2];
                wr_data = 32'd0;
            end
            ST_LEN_LO: begin
                wr_en = 1'b1;
                wr_addr = 4'd14;
                wr_data = bit_count_reg[31:0];
            end
            ST_LEN_HI: begin
                wr_en = 1'b1;
                wr_addr = 4'd15;
                wr_data = bit_count_reg[63:32];
            end
            ST_RD: begin
                rd_en = 1'b1;
                rd_addr = md5_pkg::msg_index(6'd0);
            end
            ST_ROUND: begin
                rd_en = 1'b1;
                rd_addr = md5_pkg::msg_index(next_round);
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg[0]     <= md5_pkg::IV_A;
            ch_reg[1]     <= md5_pkg::IV_B;
            ch_reg[2]     <= md5_pkg::IV_C;
            ch_reg[3]     <= md5_pkg::IV_D;
            bit_count_reg <= 64'd0;
            out_valid_reg <= 1'b0;
            closing_reg   <= 1'b0;
            padded_reg    <= 1'b0;
            second_reg    <= 1'b0;
            round_reg     <= 6'd0;
            pos_reg       <= 6'd0;
        end else begin
            // the second digest beat reloads the output register itself
            if (out_valid_reg && m_ready && state_reg != ST_OUT1) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        byte_reg    <= s_data.data_byte;
                        pos_reg     <= cur_pos;
                        closing_reg <= s_data.end_of_message;
                        padded_reg  <= 1'b0;
                        second_reg  <= 1'b0;
                        if (s_data.byte_present) begin
                            state_reg <= ST_RMW;
                        end else if (s_data.end_of_message) begin
                            state_reg <= ST_RMWPAD;
                        end
                    end
                end
                ST_RMW: begin
                    bit_count_reg <= bit_count_reg + 64'd8;
                    if (pos_reg == 6'd63) begin
                        state_reg <= ST_RD;
                    end else if (closing_reg) begin
                        pos_reg   <= pos_reg + 6'd1;
                        state_reg <= ST_RMWPAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RMWPAD: begin
                    // rd_data_reg holds the current word of pos_reg
                    padded_reg <= 1'b1;
                    second_reg <= (pos_reg >= 6'd56);
                    if (pos_reg[5:2] == 4'd15) begin
                        // pad mark in the last word: block is full
                        state_reg <= ST_RD;
                    end else begin
                        pos_reg   <= {pos_reg[5:2] + 4'd1, 2'b00};
                        state_reg <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    pos_reg <= {pos_reg[5:2] + 4'd1, 2'b00};
                    if (pos_reg[5:2] == 4'd15) begin
                        state_reg <= second_reg ? ST_RD : ST_LEN_LO;
                    end else if (!second_reg && pos_reg[5:2] == 4'd13) begin
                        state_reg <= ST_LEN_LO;
                    end
                end
                ST_LEN_LO: begin
                    state_reg <= ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    second_reg <= 1'b0;
                    state_reg  <= ST_RD;
                end
                ST_RD: begin
                    a_reg     <= ch_reg[0];
                    b_reg     <= ch_reg[1];
                    c_reg     <= ch_reg[2];
                    d_reg     <= ch_reg[3];
                    round_reg <= 6'd0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    a_reg     <= d_reg;
                    d_reg     <= c_reg;
                    c_reg     <= b_reg;
                    b_reg     <= b_reg + rot_val;
                    round_reg <= next_round;
                    if (round_reg == 6'd63) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    ch_reg[0] <= ch_reg[0] + a_reg;
                    ch_reg[1] <= ch_reg[1] + b_reg;
                    ch_reg[2] <= ch_reg[2] + c_reg;
                    ch_reg[3] <= ch_reg[3] + d_reg;
                    if (!closing_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!padded_reg) begin
                        // 64th byte came with the end mark: pad into a new block
                        pos_reg   <= 6'd0;
                        state_reg <= ST_RMWPAD;
                    end else if (second_reg) begin
                        // length block: zeros up to the length words
                        pos_reg    <= 6'd0;
                        second_reg <= 1'b0;
                        state_reg  <= ST_PAD;
                    end else begin
                        state_reg <= ST_OUT0;
                    end
                end
                ST_OUT0: begin
                    if (!out_valid_reg) begin
                        out_reg.digest_part <= {ch_reg[1], ch_reg[0]};
                        out_reg.part_last   <= 1'b0;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= ST_OUT1;
                    end
                end
                ST_OUT1: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg.digest_part <= {ch_reg[3], ch_reg[2]};
                        out_reg.part_last   <= 1'b1;
                        out_valid_reg       <= 1'b1;
                        ch_reg[0]     <= md5_pkg::IV_A;
                        ch_reg[1]     <= md5_pkg::IV_B;
                        ch_reg[2]     <= md5_pkg::IV_C;
                        ch_reg[3]     <= md5_pkg::IV_D;
                        bit_count_reg <= 64'd0;
                        closing_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // assertions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count did not end in fold");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !out_valid_reg)
        else $error("input taken while digest pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.part_last == 1'b0 && m_ready) |-> state_reg == ST_OUT1)
        else $error("first digest beat without second pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> $past(state_reg) == ST_ROUND)
        else $error("fold not after rounds");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream test of the MD5 digest block: byte messages of many lengths go in,
// each closing beat is predicted in a local digest model, and both digest
// beats are checked field by field in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    // per-round additive constants of the compression
    localparam logic [31:0] RND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Digest model plus the queue of digest beats still owed by the block.
    class digest_checker;
        logic [31:0]        chain [4];
        logic [31:0]        blk [16];
        logic [63:0]        msg_bits;
        md5_pkg::md5_out_t  parts_due [$];
        int                 errors;

        function new();
            restart();
            foreach (blk[i]) blk[i] = '0;
            errors = 0;
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            msg_bits = '0;
        endfunction

        function void place_byte(int pos, logic [7:0] val);
            if (pos % 4 == 0) begin
                blk[pos / 4] = {24'h0, val};
            end else begin
                blk[pos / 4] = blk[pos / 4] | (32'(val) << (8 * (pos % 4)));
            end
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, sum, rot;
            int          m, s;
            int          shifts [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                          '{4, 11, 16, 23}, '{6, 10, 15, 21}};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin f = d ^ (b & (c ^ d)); m = r % 16; end
                    1: begin f = c ^ (d & (b ^ c)); m = (5 * r + 1) % 16; end
                    2: begin f = b ^ c ^ d;         m = (3 * r + 5) % 16; end
                    default: begin f = c ^ (b | ~d); m = (7 * r) % 16; end
                endcase
                sum = a + f + RND_K[r] + blk[m];
                s   = shifts[r / 16][r % 4];
                rot = (sum << s) | (sum >> (32 - s));
                a = d; d = c; c = b; b = b + rot;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void note_beat(md5_pkg::md5_in_t x);
            int                pos;
            md5_pkg::md5_out_t p;
            if (x.byte_present) begin
                pos = int'(msg_bits[8:3]);
                place_byte(pos, x.data_byte);
                msg_bits += 64'd8;
                if (pos == 63) compress();
            end
            if (!x.end_of_message) return;
            pos = int'(msg_bits[8:3]);
            place_byte(pos, 8'h80);
            for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
            // no room for the length: one extra block of zeros
            if (pos >= 56) begin
                compress();
                foreach (blk[i]) blk[i] = '0;
            end
            blk[14] = msg_bits[31:0];
            blk[15] = msg_bits[63:32];
            compress();
            p.digest_part = {chain[1], chain[0]};
            p.part_last   = 1'b0;
            parts_due.push_back(p);
            p.digest_part = {chain[3], chain[2]};
            p.part_last   = 1'b1;
            parts_due.push_back(p);
            restart();
        endfunction

        function void check_part(md5_pkg::md5_out_t got);
            md5_pkg::md5_out_t want;
            if (parts_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected digest beat %h last=%b", got.digest_part, got.part_last);
                return;
            end
            want = parts_due.pop_front();
            if (got.digest_part !== want.digest_part || got.part_last !== want.part_last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("digest beat: expected %h last=%b, got %h last=%b",
                             want.digest_part, want.part_last, got.digest_part, got.part_last);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    md5_pkg::md5_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    md5_pkg::md5_out_t m_data;

    digest_checker board = new();
    int  cycles = 0;
    int  items_sent = 0;
    bit  src_calm = 1'b0;   // no source gaps while set
    bit  sink_calm = 1'b0;  // no sink stalls while set

    md5_message_digest_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: every accepted digest beat goes to the checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_part(m_data);
    end

    // sink: random stall before each beat, none while calm
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One beat: optional gap, then hold valid until the handshake. Valid is
    // left high afterwards so back-to-back beats never toggle it in one step.
    task automatic send_beat(logic [7:0] val, bit present, bit last);
        int               gap;
        md5_pkg::md5_in_t x;
        x.data_byte      = val;
        x.byte_present   = present;
        x.end_of_message = last;
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_beat(x);
        items_sent++;
    endtask

    // One message of len bytes; the close rides on the last byte or comes
    // as a bare end mark. noisy inserts ignored bare beats.
    task automatic send_message(int len, bit close_on_byte, bit noisy, bit fill_ff);
        logic [7:0] val;
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            val = fill_ff ? 8'hff : 8'($urandom);
            send_beat(val, 1'b1, close_on_byte && i == len - 1);
        end
        if (!close_on_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.parts_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, bare beats, padding boundaries, all-ones bytes
        send_beat(8'hff, 1'b0, 1'b0);
        send_message(0, 1'b0, 1'b0, 1'b0);
        send_message(1, 1'b1, 1'b0, 1'b1);
        send_message(3, 1'b0, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        send_message(55, 1'b1, 1'b0, 1'b1);
        send_message(56, 1'b0, 1'b0, 1'b0);
        send_message(63, 1'b1, 1'b0, 1'b0);
        send_message(64, 1'b0, 1'b0, 1'b1);
        // hold off until every digest beat is back
        drain();

        while (items_sent < 1500) begin
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1:    len = lens[$urandom_range(0, 9)];
                2:       len = $urandom_range(100, 200);
                default: len = $urandom_range(0, 70);
            endcase
            send_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 9) == 0) drain();
        end
        drain();
        repeat (300) @(posedge aclk);

        if (board.errors == 0 && board.parts_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
